/* src/modbus_rtu_request_framer_unit_defines.svh */
// Assertion macros shared by the request framer modules.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef MODBUS_RTU_REQUEST_FRAMER_UNIT_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define MRF_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("framer check failed");
// Implication checked at every clock edge outside reset.
`define MRF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer check failed");
`else
`define MRF_ASSERT(lbl, cond)
`define MRF_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

/* src/mrf_pkg.sv */
// Package of the Modbus RTU request framer: types, codes, constants, CRC step.
// Used by every module of the block; depends on nothing.
package mrf_pkg;

	localparam int COIL_ENTRIES_DEF   = 128;
	localparam int REG_ENTRIES_DEF    = 1024;
	localparam int MAX_WRITE_REGS_DEF = 16;
	localparam int MAX_COIL_BYTES     = 32;
	localparam int MAX_COILS          = 8 * MAX_COIL_BYTES;
	localparam int K_W                = 9;

	// Input commands.
	localparam logic [1:0] CMD_LOAD_COIL = 2'd0;
	localparam logic [1:0] CMD_LOAD_REG  = 2'd1;
	localparam logic [1:0] CMD_REQUEST   = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_FRAME = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_ERR   = 2'd2;

	// Function codes.
	localparam logic [7:0] FC_RD_COILS  = 8'd1;
	localparam logic [7:0] FC_RD_INPUTS = 8'd2;
	localparam logic [7:0] FC_RD_REGS   = 8'd3;
	localparam logic [7:0] FC_WR_COIL   = 8'd5;
	localparam logic [7:0] FC_WR_REG    = 8'd6;
	localparam logic [7:0] FC_WR_COILS  = 8'd15;
	localparam logic [7:0] FC_WR_REGS   = 8'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] COIL_ON  = 16'hFF00;
	localparam logic [15:0] COIL_OFF = 16'h0000;

	// Work kinds decided by the front end.
	typedef enum logic [3:0] {
		K_ACK,
		K_ERR,
		K_LD_COIL,
		K_LD_REG,
		K_RD,
		K_F05,
		K_F06,
		K_F15,
		K_F16
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  slave;
		logic [7:0]  fc;
		logic [15:0] addr;
		logic [15:0] vol;
		logic [15:0] data;
	} desc_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_FETCH,
		B_HDR,
		B_G_RD,
		B_G_ACC,
		B_COIL_OUT,
		B_R_RD,
		B_R_LAT,
		B_R_HI,
		B_R_LO,
		B_CRC_LO,
		B_CRC_HI,
		B_SINGLE
	} bstate_t;

	// One byte of CRC-16/MODBUS, bit by bit.
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

endpackage

/* src/modbus_rtu_request_framer_unit.sv */
// Top level of the Modbus RTU request framer.
// Depends on mrf_pkg, mrf_front and mrf_back.
//
// channel   dir  tdata (low bit first)                                  tlast      tuser
// s_*       in   slave_address, function_code, base_addr,               -          command
//                value_or_length, table_index, table_data, zero pad
// m_*       out  tx_byte                                                last_byte  status
//
// A load or a no-frame item gives a single result. Header and CRC bytes go out
// one per cycle while the output slot is free. Function 16 reads each register
// via B_R_RD and B_R_LAT, and function 15 gathers each coil via B_G_RD and B_G_ACC.
// A short queue of two items sits between front and back ends.
// After reset a clear pass over max(COIL_ENTRIES, REG_ENTRIES) entries zeroes both
// tables, and s_tready stays low until it ends. Either side may stall at any time.
module modbus_rtu_request_framer_unit
	import mrf_pkg::*;
#(
	parameter int COIL_ENTRIES   = COIL_ENTRIES_DEF,
	parameter int REG_ENTRIES    = REG_ENTRIES_DEF,
	parameter int MAX_WRITE_REGS = MAX_WRITE_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slave_address, function_code, base_addr, value_or_length, table_index,
	// table_data, from bit 0 up
	input  logic [79:0] s_tdata,
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // tx_byte
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // status
);

	logic  accept_ok;
	logic  q_valid;
	logic  q_pop;
	desc_t q_head;

	// Classification and queue.
	mrf_front #(
		.COIL_ENTRIES  (COIL_ENTRIES),
		.REG_ENTRIES   (REG_ENTRIES),
		.MAX_WRITE_REGS(MAX_WRITE_REGS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.accept_ok(accept_ok),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	// Tables, frame sequencer and output stage.
	mrf_back #(
		.COIL_ENTRIES(COIL_ENTRIES),
		.REG_ENTRIES (REG_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.accept_ok(accept_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* src/mrf_front.sv */
// Front end of the request framer: classifies input items and queues them.
// Depends on mrf_pkg and the assertion macro header.
`include "modbus_rtu_request_framer_unit_defines.svh"
module mrf_front
	import mrf_pkg::*;
#(
	parameter int COIL_ENTRIES   = COIL_ENTRIES_DEF,
	parameter int REG_ENTRIES    = REG_ENTRIES_DEF,
	parameter int MAX_WRITE_REGS = MAX_WRITE_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        accept_ok,
	output logic        q_valid,
	output desc_t       q_head,
	input  logic        q_pop
);

	logic [7:0]  slave;
	logic [7:0]  fc;
	logic [15:0] start;
	logic [15:0] vol;
	logic [9:0]  idx;
	logic [15:0] data;
	logic [16:0] span;
	desc_t       desc;
	desc_t       q_mem [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign slave = s_tdata[7:0];
	assign fc    = s_tdata[15:8];
	assign start = s_tdata[31:16];
	assign vol   = s_tdata[47:32];
	assign idx   = s_tdata[57:48];
	assign data  = s_tdata[73:58];
	assign span  = {1'b0, start} + {1'b0, vol};

	// Classify the item and run the range checks.
	always_comb begin
		desc.slave = slave;
		desc.fc    = fc;
		desc.addr  = start;
		desc.vol   = vol;
		desc.data  = data;
		desc.kind  = K_ERR;
		unique case (s_tuser)
			CMD_LOAD_COIL: begin
				desc.addr = {6'd0, idx};
				desc.kind = (17'(idx) >= 17'(COIL_ENTRIES)) ? K_ERR : K_LD_COIL;
			end
			CMD_LOAD_REG: begin
				desc.addr = {6'd0, idx};
				desc.kind = (17'(idx) >= 17'(REG_ENTRIES)) ? K_ERR : K_LD_REG;
			end
			CMD_REQUEST: begin
				unique case (fc) inside
					FC_RD_COILS, FC_RD_INPUTS, FC_RD_REGS: desc.kind = K_RD;
					FC_WR_COIL: begin
						if (vol != 16'd1)
							desc.kind = K_ACK;
						else if (17'(start) >= 17'(COIL_ENTRIES))
							desc.kind = K_ERR;
						else
							desc.kind = K_F05;
					end
					FC_WR_REG: begin
						desc.kind = (17'(start) >= 17'(REG_ENTRIES)) ? K_ERR : K_F06;
					end
					FC_WR_COILS: begin
						if (vol == 16'd0 || 17'(vol) > 17'(MAX_COILS)
								|| span > 17'(COIL_ENTRIES))
							desc.kind = K_ERR;
						else
							desc.kind = K_F15;
					end
					FC_WR_REGS: begin
						if (vol == 16'd0 || 17'(vol) > 17'(MAX_WRITE_REGS)
								|| span > 17'(REG_ENTRIES))
							desc.kind = K_ERR;
						else
							desc.kind = K_F16;
					end
					default: desc.kind = K_ACK;
				endcase
			end
			default: desc.kind = K_ERR;
		endcase
	end

	// Two-entry queue toward the back end.
	assign s_tready = accept_ok && (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = q_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= desc;
	end

	`MRF_ASSERT(a_cnt_range, cnt_q <= 2'd2)
	`MRF_ASSERT_IMP(a_pop_nonempty, q_pop, cnt_q != 2'd0)

endmodule

/* src/mrf_back.sv */
// Back end of the request framer: table memories, frame sequencer, CRC, output stage.
// Depends on mrf_pkg and the assertion macro header.
`include "modbus_rtu_request_framer_unit_defines.svh"
module mrf_back
	import mrf_pkg::*;
#(
	parameter int COIL_ENTRIES = COIL_ENTRIES_DEF,
	parameter int REG_ENTRIES  = REG_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  desc_t       q_head,
	output logic        q_pop,
	output logic        accept_ok,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	output logic [1:0]  m_tuser
);

	localparam int COIL_AW = $clog2(COIL_ENTRIES);
	localparam int REG_AW  = $clog2(REG_ENTRIES);
	localparam int CLR_N   = (COIL_ENTRIES > REG_ENTRIES) ? COIL_ENTRIES : REG_ENTRIES;
	localparam int CLR_W   = $clog2(CLR_N + 1);

	bstate_t              state_q, state_d;
	logic [CLR_W-1:0]     clr_q;
	desc_t                d_q;
	logic [2:0]           pos_q;
	logic [K_W-1:0]       k_q;
	logic [K_W-1:0]       k_inc;
	logic [7:0]           acc_q;
	logic [15:0]          word_q;
	logic [15:0]          crc_q;
	logic [1:0]           st_q;
	logic                 slot_free;
	logic                 emit;
	logic [7:0]           e_byte;
	logic                 e_last;
	logic [1:0]           e_st;
	logic                 e_crc;
	logic [7:0]           hdr_byte;
	logic [15:0]          rd_addr;
	logic [7:0]           nbytes;
	logic                 coil_we;
	logic [COIL_AW-1:0]   coil_wa;
	logic                 coil_wd;
	logic [COIL_AW-1:0]   coil_ra;
	logic                 coil_rd_q;
	logic                 reg_we;
	logic [REG_AW-1:0]    reg_wa;
	logic [15:0]          reg_wd;
	logic [REG_AW-1:0]    reg_ra;
	logic [15:0]          reg_rd_q;
	logic                 coil_mem [COIL_ENTRIES];
	logic [15:0]          reg_mem  [REG_ENTRIES];
	logic                 m_valid_q;
	logic [7:0]           m_data_q;
	logic                 m_last_q;
	logic [1:0]           m_st_q;

	assign slot_free = !m_valid_q || m_tready;
	assign accept_ok = (state_q != B_CLEAR);
	assign k_inc     = k_q + K_W'(1);
	assign rd_addr   = d_q.addr + 16'(k_q);
	assign nbytes    = 8'((17'(d_q.vol) + 17'd7) >> 3);

	// Header bytes by position.
	always_comb begin
		case (pos_q)
			3'd0:    hdr_byte = d_q.slave;
			3'd1:    hdr_byte = d_q.fc;
			3'd2:    hdr_byte = d_q.addr[15:8];
			3'd3:    hdr_byte = d_q.addr[7:0];
			3'd4:    hdr_byte = (d_q.kind == K_F05 || d_q.kind == K_F06)
				? word_q[15:8] : d_q.vol[15:8];
			3'd5:    hdr_byte = (d_q.kind == K_F05 || d_q.kind == K_F06)
				? word_q[7:0] : d_q.vol[7:0];
			3'd6:    hdr_byte = (d_q.kind == K_F15) ? nbytes : {d_q.vol[6:0], 1'b0};
			default: hdr_byte = 8'd0;
		endcase
	end

	// Next state, memory controls and byte emission.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		e_byte  = 8'd0;
		e_last  = 1'b0;
		e_st    = ST_FRAME;
		e_crc   = 1'b0;
		coil_we = 1'b0;
		coil_wa = q_head.addr[COIL_AW-1:0];
		coil_wd = |q_head.data;
		coil_ra = q_head.addr[COIL_AW-1:0];
		reg_we  = 1'b0;
		reg_wa  = q_head.addr[REG_AW-1:0];
		reg_wd  = q_head.data;
		reg_ra  = q_head.addr[REG_AW-1:0];
		unique case (state_q)
			B_CLEAR: begin
				coil_we = (32'(clr_q) < COIL_ENTRIES);
				coil_wa = clr_q[COIL_AW-1:0];
				coil_wd = 1'b0;
				reg_we  = (32'(clr_q) < REG_ENTRIES);
				reg_wa  = clr_q[REG_AW-1:0];
				reg_wd  = 16'd0;
				if (clr_q == CLR_W'(CLR_N - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_head.kind) inside
						K_LD_COIL: begin
							coil_we = 1'b1;
							state_d = B_SINGLE;
						end
						K_LD_REG: begin
							reg_we  = 1'b1;
							state_d = B_SINGLE;
						end
						K_F05, K_F06: state_d = B_FETCH;
						K_RD, K_F15, K_F16: state_d = B_HDR;
						default: state_d = B_SINGLE;
					endcase
				end
			end
			B_FETCH: state_d = B_HDR;
			B_HDR: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_byte = hdr_byte;
					e_crc  = 1'b1;
					if (pos_q == 3'd5 && d_q.kind != K_F15 && d_q.kind != K_F16)
						state_d = B_CRC_LO;
					else if (pos_q == 3'd6)
						state_d = (d_q.kind == K_F15) ? B_G_RD : B_R_RD;
				end
			end
			B_G_RD: begin
				coil_ra = rd_addr[COIL_AW-1:0];
				state_d = B_G_ACC;
			end
			B_G_ACC: begin
				state_d = (k_inc == d_q.vol[K_W-1:0] || k_q[2:0] == 3'd7)
					? B_COIL_OUT : B_G_RD;
			end
			B_COIL_OUT: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_byte  = acc_q;
					e_crc   = 1'b1;
					state_d = (k_q == d_q.vol[K_W-1:0]) ? B_CRC_LO : B_G_RD;
				end
			end
			B_R_RD: begin
				reg_ra  = rd_addr[REG_AW-1:0];
				state_d = B_R_LAT;
			end
			B_R_LAT: state_d = B_R_HI;
			B_R_HI: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_byte  = word_q[15:8];
					e_crc   = 1'b1;
					state_d = B_R_LO;
				end
			end
			B_R_LO: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_byte  = word_q[7:0];
					e_crc   = 1'b1;
					state_d = (k_inc == d_q.vol[K_W-1:0]) ? B_CRC_LO : B_R_RD;
				end
			end
			B_CRC_LO: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_byte  = crc_q[7:0];
					state_d = B_CRC_HI;
				end
			end
			B_CRC_HI: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_byte  = crc_q[15:8];
					e_last  = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_SINGLE: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_last  = 1'b1;
					e_st    = st_q;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// State register, clear counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= clr_q + CLR_W'(1);
			if (emit)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			d_q   <= q_head;
			pos_q <= 3'd0;
			k_q   <= '0;
			acc_q <= 8'd0;
			crc_q <= CRC_INIT;
			st_q  <= (q_head.kind == K_ERR) ? ST_ERR : ST_NONE;
		end
		if (state_q == B_FETCH)
			word_q <= (d_q.kind == K_F05) ? (coil_rd_q ? COIL_ON : COIL_OFF) : reg_rd_q;
		if (state_q == B_R_LAT) word_q <= reg_rd_q;
		if (state_q == B_G_ACC) begin
			acc_q[k_q[2:0]] <= coil_rd_q;
			k_q             <= k_inc;
		end
		if (state_q == B_COIL_OUT && slot_free) acc_q <= 8'd0;
		if (state_q == B_R_LO && slot_free) k_q <= k_inc;
		if (state_q == B_HDR && slot_free) pos_q <= pos_q + 3'd1;
		if (emit && e_crc) crc_q <= crc_byte(crc_q, e_byte);
		if (emit) begin
			m_data_q <= e_byte;
			m_last_q <= e_last;
			m_st_q   <= e_st;
		end
	end

	// Coil table memory.
	always_ff @(posedge clk) begin
		if (coil_we) coil_mem[coil_wa] <= coil_wd;
		coil_rd_q <= coil_mem[coil_ra];
	end

	// Register table memory.
	always_ff @(posedge clk) begin
		if (reg_we) reg_mem[reg_wa] <= reg_wd;
		reg_rd_q <= reg_mem[reg_ra];
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_st_q;

	`MRF_ASSERT_IMP(a_status_last, m_valid_q && m_st_q != ST_FRAME, m_last_q)
	`MRF_ASSERT_IMP(a_clear_quiet, state_q == B_CLEAR, !m_valid_q && !q_pop)

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the Modbus RTU request framer unit.
// Depends on mrf_pkg and modbus_rtu_request_framer_unit; predicts every frame byte and CRC.
`timescale 1ns / 100ps

module tb_top;
	import mrf_pkg::*;

	localparam int NCOIL = COIL_ENTRIES_DEF;
	localparam int NREG  = REG_ENTRIES_DEF;
	localparam int NWREG = MAX_WRITE_REGS_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
		logic [1:0] status;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // slave, fc, start, value_or_length, index, data from bit 0 up
	logic [1:0]  s_tuser;   // command
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // tx_byte
	logic        m_tlast;
	logic [1:0]  m_tuser;   // status

	// Shadow copies of the block's tables and the queue of predicted bytes.
	logic        coil_shadow [NCOIL];
	logic [15:0] reg_shadow [NREG];
	frame_byte_t pending_bytes [$];

	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          recv_hold;

	modbus_rtu_request_framer_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
		logic [15:0] x;
		x = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
		return x;
	endfunction

	function automatic void push_single(logic [1:0] st);
		pending_bytes.push_back('{tx_byte: 8'h00, last_byte: 1'b1, status: st});
	endfunction

	// Appends the CRC and queues the frame one byte per result.
	function automatic void push_frame(logic [7:0] fr [$]);
		logic [15:0] crc;
		crc = 16'hFFFF;
		foreach (fr[k]) crc = crc_update(crc, fr[k]);
		fr.push_back(crc[7:0]);
		fr.push_back(crc[15:8]);
		foreach (fr[k])
			pending_bytes.push_back('{tx_byte: fr[k], last_byte: (k == fr.size() - 1),
				status: ST_FRAME});
	endfunction

	// Predicts the results of one accepted item and updates the shadow tables.
	function automatic void predict_item(logic [1:0] cmd, logic [7:0] slave, logic [7:0] fc,
			logic [15:0] start, logic [15:0] vol, logic [9:0] idx, logic [15:0] data);
		logic [7:0]  fr [$];
		logic [15:0] word;
		int          nbytes;
		if (cmd == CMD_LOAD_COIL) begin
			if (idx >= NCOIL) push_single(ST_ERR);
			else begin
				coil_shadow[idx] = (data != 0);
				push_single(ST_NONE);
			end
			return;
		end
		if (cmd == CMD_LOAD_REG) begin
			if (idx >= NREG) push_single(ST_ERR);
			else begin
				reg_shadow[idx] = data;
				push_single(ST_NONE);
			end
			return;
		end
		if (cmd != CMD_REQUEST) begin
			push_single(ST_ERR);
			return;
		end
		fr = '{slave, fc, start[15:8], start[7:0]};
		case (fc) inside
			FC_RD_COILS, FC_RD_INPUTS, FC_RD_REGS: begin
				fr.push_back(vol[15:8]);
				fr.push_back(vol[7:0]);
				push_frame(fr);
			end
			FC_WR_COIL: begin
				if (vol != 1) push_single(ST_NONE);
				else if (start >= NCOIL) push_single(ST_ERR);
				else begin
					word = coil_shadow[start] ? COIL_ON : COIL_OFF;
					fr.push_back(word[15:8]);
					fr.push_back(word[7:0]);
					push_frame(fr);
				end
			end
			FC_WR_REG: begin
				if (start >= NREG) push_single(ST_ERR);
				else begin
					word = reg_shadow[start];
					fr.push_back(word[15:8]);
					fr.push_back(word[7:0]);
					push_frame(fr);
				end
			end
			FC_WR_COILS: begin
				if (vol == 0 || vol > MAX_COILS || 32'(start) + vol > NCOIL) push_single(ST_ERR);
				else begin
					nbytes = (vol + 7) / 8;
					fr.push_back(vol[15:8]);
					fr.push_back(vol[7:0]);
					fr.push_back(8'(nbytes));
					for (int k = 0; k < nbytes; k++) fr.push_back(8'h00);
					for (int k = 0; k < vol; k++)
						if (coil_shadow[start + k]) fr[7 + k / 8][k % 8] = 1'b1;
					push_frame(fr);
				end
			end
			FC_WR_REGS: begin
				if (vol == 0 || vol > NWREG || 32'(start) + vol > NREG) push_single(ST_ERR);
				else begin
					fr.push_back(vol[15:8]);
					fr.push_back(vol[7:0]);
					fr.push_back(8'(2 * vol));
					for (int k = 0; k < vol; k++) begin
						word = reg_shadow[start + k];
						fr.push_back(word[15:8]);
						fr.push_back(word[7:0]);
					end
					push_frame(fr);
				end
			end
			default: push_single(ST_NONE);
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Sends one item and predicts its results once it is accepted.
	// Valid stays high after acceptance so that the next item can follow at once;
	// an idle gap or a drain drops it.
	task automatic send_item(logic [1:0] cmd, logic [7:0] slave, logic [7:0] fc,
			logic [15:0] start, logic [15:0] vol, logic [9:0] idx, logic [15:0] data);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'd0, data, idx, vol, start, fc, slave};
		do @(posedge clk); while (!s_tready);
		predict_item(cmd, slave, fc, start, vol, idx, data);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold when asked.
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= !recv_hold && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	// Checker of every accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) report_mismatch("unexpected result", m_tdata, 0);
			else begin
				frame_byte_t want;
				want = pending_bytes.pop_front();
				if (m_tdata !== want.tx_byte) report_mismatch("tx_byte", m_tdata, want.tx_byte);
				if (m_tlast !== want.last_byte) report_mismatch("last_byte", m_tlast, want.last_byte);
				if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
			end
		end
	end

	// Watchdog over cycles without any accepted item or result.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_loads_and_simple();
		send_item(CMD_LOAD_COIL, 8'h00, 8'h00, 16'h0000, 16'h0000, 10'd0, 16'h0001);
		send_item(CMD_LOAD_COIL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 10'd127, 16'h8000);
		send_item(CMD_LOAD_COIL, 8'h00, 8'h00, 16'h0000, 16'h0000, 10'd128, 16'h0001);
		send_item(CMD_LOAD_COIL, 8'h00, 8'h00, 16'h0000, 16'h0000, 10'd1023, 16'hFFFF);
		send_item(CMD_LOAD_REG, 8'h00, 8'h00, 16'h0000, 16'h0000, 10'd0, 16'hFFFF);
		send_item(CMD_LOAD_REG, 8'h00, 8'h00, 16'h0000, 16'h0000, 10'd1023, 16'hA55A);
		send_item(2'd3, 8'hFF, FC_RD_REGS, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF);
	endtask

	task automatic test_requests();
		send_item(CMD_REQUEST, 8'h00, FC_RD_COILS, 16'h0000, 16'h0000, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'hFF, FC_RD_INPUTS, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF);
		send_item(CMD_REQUEST, 8'h11, FC_RD_REGS, 16'h006B, 16'h0003, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h11, 8'd4, 16'h0000, 16'h0001, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h01, FC_WR_COIL, 16'd0, 16'd1, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h01, FC_WR_COIL, 16'd127, 16'd1, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h01, FC_WR_COIL, 16'd5, 16'd0, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h01, FC_WR_COIL, 16'd128, 16'd1, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h02, FC_WR_REG, 16'd1023, 16'd0, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h02, FC_WR_REG, 16'd1024, 16'd0, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h03, FC_WR_COILS, 16'd0, 16'd128, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h03, FC_WR_COILS, 16'd0, 16'd0, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h03, FC_WR_COILS, 16'd120, 16'd9, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h04, FC_WR_REGS, 16'd1008, 16'd16, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h04, FC_WR_REGS, 16'd0, 16'd17, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h04, FC_WR_REGS, 16'd1020, 16'd5, 10'd0, 16'd0);
		send_item(CMD_REQUEST, 8'h04, FC_WR_REGS, 16'd0, 16'd0, 10'd0, 16'd0);
	endtask

	// Random mix: mostly loads and valid requests, some random noise.
	task automatic test_random(int count);
		logic [7:0]  fc;
		logic [15:0] start, vol;
		int          pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 20)
				send_item(CMD_LOAD_COIL, 8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom), 10'($urandom_range(NCOIL + 20)),
					($urandom_range(1) ? 16'($urandom) : 16'd0));
			else if (pick < 35)
				send_item(CMD_LOAD_REG, 8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom), 10'($urandom), 16'($urandom));
			else if (pick < 85) begin
				case ($urandom_range(6))
					0: fc = FC_RD_COILS; 1: fc = FC_RD_INPUTS; 2: fc = FC_RD_REGS;
					3: fc = FC_WR_COIL; 4: fc = FC_WR_REG; 5: fc = FC_WR_COILS;
					default: fc = FC_WR_REGS;
				endcase
				case (fc)
					FC_WR_COIL: begin
						start = 16'($urandom_range(NCOIL - 1));
						vol = $urandom_range(9) ? 16'd1 : 16'($urandom);
					end
					FC_WR_REG: begin start = 16'($urandom_range(NREG - 1)); vol = 16'($urandom); end
					FC_WR_COILS: begin
						vol = 16'($urandom_range(1, 40));
						start = 16'($urandom_range(NCOIL - 1));
						if (start + vol > NCOIL && $urandom_range(3) != 0) start = 16'(NCOIL - vol);
					end
					FC_WR_REGS: begin
						vol = 16'($urandom_range(1, NWREG + 1));
						start = 16'($urandom_range(NREG - 1));
						if (start + vol > NREG) start = 16'(NREG - vol);
					end
					default: begin start = 16'($urandom); vol = 16'($urandom); end
				endcase
				send_item(CMD_REQUEST, 8'($urandom), fc, start, vol, 10'($urandom), 16'($urandom));
			end else
				send_item(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom), 10'($urandom), 16'($urandom));
		end
	endtask

	// Receiver holds off while the sender keeps offering, then the sender waits for drain.
	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			begin
				test_random(12);
				wait_drained();
			end
		join
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (coil_shadow[k]) coil_shadow[k] = 1'b0;
		foreach (reg_shadow[k]) reg_shadow[k] = 16'h0000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_loads_and_simple();
		test_requests();
		test_random(80);
		send_idle_pct = 55;
		test_random(70);
		send_idle_pct = 0;
		recv_stall_pct = 55;
		test_random(70);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		test_random(70);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		test_random(20);
		wait_drained();

		if (error_count == 0 && pending_bytes.size() == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/mrf_pkg.sv
src/mrf_front.sv
src/mrf_back.sv
src/modbus_rtu_request_framer_unit.sv
tb/tb_top.sv
